// ===== sv/lphi_pkg.sv =====
// Package for the linear-probe hash index: request and status codes,
// sizing constants and the controller state type. No dependencies.
`default_nettype none

package lphi_pkg;

    localparam int unsigned MAX_BUCKETS_LOG2_DEF = 12;
    localparam logic [4:0]  MIN_BUCKETS_LOG2     = 5'd2;
    localparam logic [3:0]  SIZE_LOG2_RESET      = 4'd12;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_MISS    = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ZERO    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/linear_probe_hash_index_core.sv =====
// Linear-probe hash index: key and value memories, probe sequencer, clear sweep.
// Depends on lphi_pkg.
//
// Insert/lookup: the probe reads one bucket per cycle from the value/key memory
// port; the result is registered when the probe stops.
// Zero-value insert and unused request type: result in the cycle after the request.
// Clear: zeroes all 2**MAX_BUCKETS_LOG2 value entries, then registers its result.
// Reset: busy during a sweep that empties all 2**MAX_BUCKETS_LOG2 value entries.
// A new request is taken in the cycle its predecessor's result is shown.
`default_nettype none

module linear_probe_hash_index_core
    import lphi_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS_LOG2 = MAX_BUCKETS_LOG2_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [63:0] i_key_prefix,
    input  wire logic [31:0] i_block_number,
    output logic             o_result_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_found_block
);

    localparam int unsigned AW    = MAX_BUCKETS_LOG2;
    localparam int unsigned Depth = 2 ** MAX_BUCKETS_LOG2;
    localparam logic [4:0]  MaxL  = 5'(MAX_BUCKETS_LOG2);

    logic [63:0] mem_key [Depth];
    logic [31:0] mem_val [Depth];

    t_state      r_state, n_state;
    logic [3:0]  r_size_log2;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic        r_report, n_report;
    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_status, n_status;
    logic [31:0] r_found, n_found;
    logic [1:0]  r_req, n_req;
    logic [63:0] r_key, n_key;
    logic [31:0] r_val, n_val;
    logic [AW-1:0] r_mask, n_mask;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [63:0] r_rd_key;
    logic [31:0] r_rd_val;

    logic [4:0]    w_act;
    logic [AW-1:0] w_mask;
    logic [AW-1:0] w_home;
    logic [AW-1:0] w_next_idx;
    logic          w_accept;
    logic          w_empty;
    logic          w_match;
    logic          w_last;
    logic          w_clr_end;
    logic          w_done;

    logic          w_rd_en_unused;
    logic [AW-1:0] w_rd_addr;
    logic          w_val_we;
    logic [AW-1:0] w_val_waddr;
    logic [31:0]   w_val_wdata;
    logic          w_key_we;

    always_comb begin
        if ({1'b0, r_size_log2} < MIN_BUCKETS_LOG2) begin
            w_act = MIN_BUCKETS_LOG2;
        end else if ({1'b0, r_size_log2} > MaxL) begin
            w_act = MaxL;
        end else begin
            w_act = {1'b0, r_size_log2};
        end
    end

    assign w_mask     = ~({AW{1'b1}} << w_act);
    assign w_home     = i_key_prefix[AW-1:0] & w_mask;
    assign w_next_idx = (r_idx + 1'b1) & r_mask;
    assign w_accept   = start && (r_state == S_IDLE);
    assign w_empty    = (r_rd_val == 32'd0);
    assign w_match    = (r_rd_key == r_key);
    assign w_last     = (r_cnt == r_mask);
    assign w_clr_end  = (r_clr_addr == {AW{1'b1}});
    assign w_done     = w_empty || w_match || w_last;
    assign w_rd_en_unused = 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_clr_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_CLEAR) begin
                        n_state = S_CLEAR;
                    end else if ((i_req_type == REQ_INSERT && i_block_number != 32'd0) ||
                                 i_req_type == REQ_LOOKUP) begin
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (w_done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath, memory controls and results
    always_comb begin
        n_clr_addr  = r_clr_addr;
        n_report    = r_report;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_found     = r_found;
        n_req       = r_req;
        n_key       = r_key;
        n_val       = r_val;
        n_mask      = r_mask;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        w_rd_addr   = w_next_idx;
        w_val_we    = 1'b0;
        w_val_waddr = r_idx;
        w_val_wdata = r_val;
        w_key_we    = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_val_we    = 1'b1;
                w_val_waddr = r_clr_addr;
                w_val_wdata = 32'd0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (w_clr_end && r_report) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_CLEARED;
                    n_found     = 32'd0;
                    n_report    = 1'b0;
                end
            end
            S_IDLE: begin
                w_rd_addr = w_home;
                if (w_accept) begin
                    n_req  = i_req_type;
                    n_key  = i_key_prefix;
                    n_val  = i_block_number;
                    n_mask = w_mask;
                    n_idx  = w_home;
                    n_cnt  = '0;
                    case (i_req_type)
                        REQ_INSERT: begin
                            if (i_block_number == 32'd0) begin
                                n_out_valid = 1'b1;
                                n_status    = ST_ZERO;
                                n_found     = 32'd0;
                            end
                        end
                        REQ_LOOKUP: ;
                        REQ_CLEAR: begin
                            n_clr_addr = '0;
                            n_report   = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_status    = ST_MISS;
                            n_found     = 32'd0;
                        end
                    endcase
                end
            end
            S_PROBE: begin
                n_idx = w_next_idx;
                n_cnt = r_cnt + 1'b1;
                if (w_done) begin
                    n_out_valid = 1'b1;
                    n_found     = 32'd0;
                end
                if (r_req == REQ_INSERT) begin
                    if (w_empty || w_match) begin
                        w_val_we = 1'b1;
                        w_key_we = 1'b1;
                        n_status = ST_OK;
                    end else if (w_last) begin
                        n_status = ST_FULL;
                    end
                end else begin
                    if (w_empty) begin
                        n_status = ST_MISS;
                    end else if (w_match) begin
                        n_status = ST_OK;
                        n_found  = r_rd_val;
                    end else if (w_last) begin
                        n_status = ST_MISS;
                    end
                end
            end
            default: ;
        endcase
    end

    // memories: one write, one registered read per cycle each; a probe never
    // reads the bucket written at the same edge
    always_ff @(posedge i_clk) begin
        if (w_val_we) mem_val[w_val_waddr] <= w_val_wdata;
        r_rd_val <= mem_val[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_key_we) mem_key[r_idx] <= r_key;
        r_rd_key <= mem_key[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_size_log2 <= SIZE_LOG2_RESET;
            r_clr_addr  <= '0;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_size_log2 <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_req    <= n_req;
        r_key    <= n_key;
        r_val    <= n_val;
        r_mask   <= n_mask;
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
    end

    assign busy           = (r_state != S_IDLE) || w_rd_en_unused;
    assign o_result_valid = r_out_valid;
    assign o_status       = r_status;
    assign o_found_block  = r_found;

endmodule

`default_nettype wire

// ===== sv/lphi_checker.sv =====
// Port-level checks for linear_probe_hash_index_core, attached by bind.
// Depends on lphi_pkg.
`default_nettype none

module lphi_checker
    import lphi_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  i_req_type,
    input wire logic [31:0] i_block_number,
    input wire logic        o_result_valid,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_found_block
);

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_found_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_status != ST_OK |-> o_found_block == 32'd0)
        else $error("found block nonzero without hit");

    a_zero_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type == REQ_INSERT && i_block_number == 32'd0
        |=> o_result_valid && o_status == ST_ZERO && !busy)
        else $error("zero value insert not rejected at once");

    a_probe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req_type == REQ_LOOKUP || i_req_type == REQ_CLEAR ||
        (i_req_type == REQ_INSERT && i_block_number != 32'd0))
        |=> busy && !o_result_valid)
        else $error("request did not occupy the table");

endmodule

bind linear_probe_hash_index_core lphi_checker u_lphi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_req_type     (i_req_type),
    .i_block_number (i_block_number),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_found_block  (o_found_block)
);

`default_nettype wire
